>>> rtl/morse_edge_timing_decoder_assert.svh
// Assertion macros shared by the checker modules of the Morse edge-timing decoder.
`ifndef MORSE_EDGE_TIMING_DECODER_ASSERT_SVH
`define MORSE_EDGE_TIMING_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define MTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mtd assertion failed");

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define MTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mtd assertion failed");

`endif

>>> rtl/mtd_pkg.sv
// Types, register indexes and the symbol table of the Morse edge-timing decoder.
package mtd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DOT_MIN  = 3'd0;
    localparam logic [2:0] CFG_DOT_MAX  = 3'd1;
    localparam logic [2:0] CFG_LONG_MIN = 3'd2;
    localparam logic [2:0] CFG_LONG_MAX = 3'd3;
    localparam logic [2:0] CFG_WORD_MIN = 3'd4;
    localparam logic [2:0] CFG_WORD_MAX = 3'd5;

    // Reset values of the timing windows, in milliseconds.
    localparam logic [15:0] RST_DOT_MIN  = 16'd245;
    localparam logic [15:0] RST_DOT_MAX  = 16'd255;
    localparam logic [15:0] RST_LONG_MIN = 16'd745;
    localparam logic [15:0] RST_LONG_MAX = 16'd755;
    localparam logic [15:0] RST_WORD_MIN = 16'd995;
    localparam logic [15:0] RST_WORD_MAX = 16'd1005;

    // Character codes.
    localparam logic [6:0] CHAR_NONE  = 7'd0;
    localparam logic [6:0] CHAR_SPACE = 7'd32;

    // Result queue depth; one key event adds at most two results.
    localparam int RESULT_DEPTH = 4;

    // One key event request.
    typedef struct packed {
        logic        key_level;
        logic [31:0] time_ms;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic [6:0] character;
        logic       last;
    } t_out_item;

    // Look up a buffered symbol. Element i sits in bit i of code, a dash is 1.
    // Symbols longer than five elements never match.
    function automatic logic [6:0] lookup_symbol(input logic [2:0] cnt, input logic [4:0] code);
        logic [6:0] ch;
        ch = CHAR_NONE;
        case ({cnt, code})
            {3'd2, 5'b00010}: ch = 7'h41; // A
            {3'd4, 5'b00001}: ch = 7'h42; // B
            {3'd4, 5'b00101}: ch = 7'h43; // C
            {3'd3, 5'b00001}: ch = 7'h44; // D
            {3'd1, 5'b00000}: ch = 7'h45; // E
            {3'd4, 5'b00100}: ch = 7'h46; // F
            {3'd3, 5'b00011}: ch = 7'h47; // G
            {3'd4, 5'b00000}: ch = 7'h48; // H
            {3'd2, 5'b00000}: ch = 7'h49; // I
            {3'd4, 5'b01110}: ch = 7'h4A; // J
            {3'd3, 5'b00101}: ch = 7'h4B; // K
            {3'd4, 5'b00010}: ch = 7'h4C; // L
            {3'd2, 5'b00011}: ch = 7'h4D; // M
            {3'd2, 5'b00001}: ch = 7'h4E; // N
            {3'd3, 5'b00111}: ch = 7'h4F; // O
            {3'd4, 5'b00110}: ch = 7'h50; // P
            {3'd4, 5'b01011}: ch = 7'h51; // Q
            {3'd3, 5'b00010}: ch = 7'h52; // R
            {3'd3, 5'b00000}: ch = 7'h53; // S
            {3'd1, 5'b00001}: ch = 7'h54; // T
            {3'd3, 5'b00100}: ch = 7'h55; // U
            {3'd4, 5'b01000}: ch = 7'h56; // V
            {3'd3, 5'b00110}: ch = 7'h57; // W
            {3'd4, 5'b01001}: ch = 7'h58; // X
            {3'd4, 5'b01101}: ch = 7'h59; // Y
            {3'd4, 5'b00011}: ch = 7'h5A; // Z
            {3'd5, 5'b11110}: ch = 7'h31; // 1
            {3'd5, 5'b11100}: ch = 7'h32; // 2
            {3'd5, 5'b11000}: ch = 7'h33; // 3
            {3'd5, 5'b10000}: ch = 7'h34; // 4
            {3'd5, 5'b00000}: ch = 7'h35; // 5
            {3'd5, 5'b00001}: ch = 7'h36; // 6
            {3'd5, 5'b00011}: ch = 7'h37; // 7
            {3'd5, 5'b00111}: ch = 7'h38; // 8
            {3'd5, 5'b01111}: ch = 7'h39; // 9
            {3'd5, 5'b11111}: ch = 7'h30; // 0
            default:          ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/morse_edge_timing_decoder.sv
// Morse edge-timing decoder: key events in, decoded ASCII characters out.
//
//   channel  direction  handshake            payload
//   in       input      i_in_valid/o_in_stall  mtd_pkg::t_in_item (key_level, time_ms)
//   out      output     o_out_valid/i_out_stall mtd_pkg::t_out_item (character, last)
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A key event is classified and the symbol buffer updated in the cycle it is accepted;
// its zero, one or two results enter a four-entry result queue that feeds the output.
// One event is accepted per cycle while the queue holds two results or fewer; the queue
// drains one result per cycle while i_out_stall is low; two results leave one at a time.
// Reset (synchronous, active low) empties the queue, clears the key state and restores
// the default windows. Configuration writes are always ready.
module morse_edge_timing_decoder #(
    parameter int MAX_ELEMENTS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mtd_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mtd_pkg::t_out_item o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int PTR_W = $clog2(mtd_pkg::RESULT_DEPTH);
    localparam int QCNT_W = $clog2(mtd_pkg::RESULT_DEPTH + 1);

    // Timing window registers.
    logic [15:0] r_dot_min, r_dot_max, r_long_min, r_long_max, r_word_min, r_word_max;

    // Key state and symbol buffer.
    logic                    r_prev_level, n_prev_level;
    logic [31:0]             r_prev_time, n_prev_time;
    logic [MAX_ELEMENTS-1:0] r_elem_bits, n_elem_bits;
    logic [CNT_W-1:0]        r_elem_count, n_elem_count;
    logic                    r_overflow, n_overflow;

    // Result queue.
    mtd_pkg::t_out_item r_queue [mtd_pkg::RESULT_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_q_count, n_q_count;

    logic        in_accept, out_accept;
    logic [31:0] elapsed;
    logic        rise, fall, in_dot, in_long, in_word;
    logic        do_decode, emit_space, do_append, char_valid;
    logic [6:0]  dec_char;
    logic [1:0]  push_count;
    mtd_pkg::t_out_item item0, item1;

    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_min  <= mtd_pkg::RST_DOT_MIN;
            r_dot_max  <= mtd_pkg::RST_DOT_MAX;
            r_long_min <= mtd_pkg::RST_LONG_MIN;
            r_long_max <= mtd_pkg::RST_LONG_MAX;
            r_word_min <= mtd_pkg::RST_WORD_MIN;
            r_word_max <= mtd_pkg::RST_WORD_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mtd_pkg::CFG_DOT_MIN:  r_dot_min  <= i_cfg_data;
                mtd_pkg::CFG_DOT_MAX:  r_dot_max  <= i_cfg_data;
                mtd_pkg::CFG_LONG_MIN: r_long_min <= i_cfg_data;
                mtd_pkg::CFG_LONG_MAX: r_long_max <= i_cfg_data;
                mtd_pkg::CFG_WORD_MIN: r_word_min <= i_cfg_data;
                mtd_pkg::CFG_WORD_MAX: r_word_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshakes: accept only while the queue has room for two results.
    assign o_in_stall  = (r_q_count > QCNT_W'(mtd_pkg::RESULT_DEPTH - 2));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_q_count != '0);
    assign out_accept  = o_out_valid && !i_out_stall;
    assign o_out       = r_queue[r_rd_ptr];

    // Edge classification and window tests; all windows are exclusive.
    always_comb begin
        elapsed = i_in.time_ms - r_prev_time;
        rise    = i_in.key_level && !r_prev_level;
        fall    = !i_in.key_level && r_prev_level;
        in_dot  = (elapsed > {16'd0, r_dot_min})  && (elapsed < {16'd0, r_dot_max});
        in_long = (elapsed > {16'd0, r_long_min}) && (elapsed < {16'd0, r_long_max});
        in_word = (elapsed > {16'd0, r_word_min}) && (elapsed < {16'd0, r_word_max});

        emit_space = rise && !in_long && in_word;
        do_decode  = (rise && (in_long || in_word)) || (fall && !in_dot && !in_long);
        do_append  = fall && (in_dot || in_long);

        // An overflowed or empty buffer decodes to nothing.
        if (r_overflow || (r_elem_count == '0)) begin
            dec_char = mtd_pkg::CHAR_NONE;
        end else begin
            dec_char = mtd_pkg::lookup_symbol(3'(r_elem_count), r_elem_bits[4:0]);
        end
        char_valid = do_decode && (dec_char != mtd_pkg::CHAR_NONE);

        // Results: the character first, then the word space.
        push_count      = {1'b0, char_valid} + {1'b0, emit_space};
        item0.character = char_valid ? dec_char : mtd_pkg::CHAR_SPACE;
        item0.last      = !(char_valid && emit_space);
        item1.character = mtd_pkg::CHAR_SPACE;
        item1.last      = 1'b1;
    end

    // Next key state and symbol buffer.
    always_comb begin
        n_prev_level = r_prev_level;
        n_prev_time  = r_prev_time;
        n_elem_bits  = r_elem_bits;
        n_elem_count = r_elem_count;
        n_overflow   = r_overflow;
        if (in_accept) begin
            n_prev_level = i_in.key_level;
            n_prev_time  = i_in.time_ms;
            if (do_decode) begin
                n_elem_bits  = '0;
                n_elem_count = '0;
                n_overflow   = 1'b0;
            end else if (do_append) begin
                if (r_elem_count >= CNT_W'(MAX_ELEMENTS)) begin
                    n_overflow = 1'b1;
                end else begin
                    n_elem_bits  = r_elem_bits | (MAX_ELEMENTS'(!in_dot) << r_elem_count);
                    n_elem_count = r_elem_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_prev_time  <= '0;
            r_elem_bits  <= '0;
            r_elem_count <= '0;
            r_overflow   <= 1'b0;
        end else begin
            r_prev_level <= n_prev_level;
            r_prev_time  <= n_prev_time;
            r_elem_bits  <= n_elem_bits;
            r_elem_count <= n_elem_count;
            r_overflow   <= n_overflow;
        end
    end

    // Result queue occupancy.
    always_comb begin
        n_q_count = r_q_count;
        if (in_accept) begin
            n_q_count = n_q_count + QCNT_W'(push_count);
        end
        if (out_accept) begin
            n_q_count = n_q_count - QCNT_W'(1);
        end
    end

    // Result queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_q_count <= '0;
        end else begin
            r_q_count <= n_q_count;
            if (in_accept) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(push_count);
            end
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (in_accept && (push_count != 2'd0)) begin
            r_queue[r_wr_ptr] <= item0;
        end
        if (in_accept && (push_count == 2'd2)) begin
            r_queue[r_wr_ptr + PTR_W'(1)] <= item1;
        end
    end

endmodule

>>> rtl/mtd_checker.sv
// Port-level checker for the Morse edge-timing decoder, bound to the top level.
`include "morse_edge_timing_decoder_assert.svh"

module mtd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mtd_pkg::t_out_item o_out
);

    logic out_is_char, out_is_space, first_moves;

    // Classify the shown result and note when a non-final one is taken.
    assign out_is_space = (o_out.character == mtd_pkg::CHAR_SPACE);
    assign out_is_char  = !out_is_space && (o_out.character != mtd_pkg::CHAR_NONE);
    assign first_moves  = o_out_valid && !o_out.last && !i_out_stall;

    // A stalled result holds its payload.
    `MTD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

    // A result that is not last is a decoded character, never a space or nothing.
    `MTD_ASSERT_NOW(a_first_is_char, o_out_valid && !o_out.last, out_is_char)

    // The result after a non-final one is the word space that closes the event.
    `MTD_ASSERT_NEXT(a_space_follows, first_moves, o_out_valid && o_out.last && out_is_space)

    // Nothing is shown in the first cycle after reset.
    `MTD_ASSERT_NOW(a_empty_after_reset, !$past(i_rst_n), !o_out_valid)

endmodule

bind morse_edge_timing_decoder mtd_checker u_mtd_checker (.*);

>>> sim/morse_decode_check.sv
// Checker module: predicts the decoded characters of the Morse edge-timing decoder and compares.
module morse_decode_check #(
    parameter int MAX_ELEMENTS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  mtd_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  mtd_pkg::t_out_item i_out,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Timing windows as last written, in milliseconds.
    logic [15:0] dot_min, dot_max, long_min, long_max, word_min, word_max;

    // Key state and the symbol being collected; element i sits in bit i, a dash is 1.
    logic        prev_level;
    logic [31:0] prev_time;
    logic [7:0]  sym_bits;
    int          sym_count;
    logic        sym_overflow;

    // Characters still to come out of the block, oldest first.
    mtd_pkg::t_out_item expected_chars[$];
    int                 fail_total = 0;

    // Letters and digits with their codes, in matching order.
    string glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";
    string morse_codes [36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..", ".----", "..---", "...--",
        "....-", ".....", "-....", "--...", "---..", "----.", "-----"
    };

    // Every window excludes both of its bounds.
    function automatic bit in_window(input logic [31:0] t, input logic [15:0] lo, hi);
        return (t > {16'd0, lo}) && (t < {16'd0, hi});
    endfunction

    // A full buffer drops the element and marks the symbol as overflowed.
    function automatic void add_element(input bit dash);
        if (sym_count >= MAX_ELEMENTS) begin
            sym_overflow = 1'b1;
        end else begin
            sym_bits[sym_count] = dash;
            sym_count++;
        end
    endfunction

    // Look the buffered symbol up and clear the buffer; CHAR_NONE when nothing matches.
    function automatic logic [6:0] decode_symbol();
        logic [6:0] ch;
        byte        glyph;
        bit         hit;
        int         k, j;
        ch = mtd_pkg::CHAR_NONE;
        if (!sym_overflow && sym_count != 0) begin
            for (k = 0; k < 36; k++) begin
                if (ch == mtd_pkg::CHAR_NONE && morse_codes[k].len() == sym_count) begin
                    hit = 1'b1;
                    for (j = 0; j < sym_count; j++) begin
                        if ((morse_codes[k][j] == "-") != sym_bits[j]) hit = 1'b0;
                    end
                    if (hit) begin
                        glyph = glyphs[k];
                        ch = glyph[6:0];
                    end
                end
            end
        end
        sym_bits = '0;
        sym_count = 0;
        sym_overflow = 1'b0;
        return ch;
    endfunction

    // Work out the characters that one key event request causes.
    function automatic void predict_key_event(input mtd_pkg::t_in_item ev);
        logic [31:0]        elapsed;
        logic [6:0]         ch;
        logic [6:0]         chars[$];
        mtd_pkg::t_out_item res;
        int                 k;
        elapsed = ev.time_ms - prev_time;
        if (ev.key_level && !prev_level) begin
            // Rising edge: the elapsed time was a gap.
            if (in_window(elapsed, long_min, long_max)) begin
                ch = decode_symbol();
                if (ch != mtd_pkg::CHAR_NONE) chars.push_back(ch);
            end else if (in_window(elapsed, word_min, word_max)) begin
                ch = decode_symbol();
                if (ch != mtd_pkg::CHAR_NONE) chars.push_back(ch);
                chars.push_back(mtd_pkg::CHAR_SPACE);
            end
        end else if (!ev.key_level && prev_level) begin
            // Falling edge: the elapsed time was a mark.
            if (in_window(elapsed, dot_min, dot_max)) begin
                add_element(1'b0);
            end else if (in_window(elapsed, long_min, long_max)) begin
                add_element(1'b1);
            end else begin
                ch = decode_symbol();
                if (ch != mtd_pkg::CHAR_NONE) chars.push_back(ch);
            end
        end
        prev_time = ev.time_ms;
        prev_level = ev.key_level;
        for (k = 0; k < chars.size(); k++) begin
            res.character = chars[k];
            res.last = (k == chars.size() - 1);
            expected_chars.push_back(res);
        end
    endfunction

    // Compare one result request with the oldest expected character.
    function automatic void compare_result(input mtd_pkg::t_out_item got);
        mtd_pkg::t_out_item want;
        if (expected_chars.size() == 0) begin
            if (fail_total < 10)
                $display("unexpected result: character %0d last %0d", got.character, got.last);
            fail_total++;
        end else begin
            want = expected_chars.pop_front();
            if (want.character !== got.character || want.last !== got.last) begin
                if (fail_total < 10)
                    $display("result mismatch: expected character %0d last %0d, got %0d last %0d",
                             want.character, want.last, got.character, got.last);
                fail_total++;
            end
        end
    endfunction

    // Follow the three channels at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dot_min = mtd_pkg::RST_DOT_MIN;
            dot_max = mtd_pkg::RST_DOT_MAX;
            long_min = mtd_pkg::RST_LONG_MIN;
            long_max = mtd_pkg::RST_LONG_MAX;
            word_min = mtd_pkg::RST_WORD_MIN;
            word_max = mtd_pkg::RST_WORD_MAX;
            prev_level = 1'b0;
            prev_time = '0;
            sym_bits = '0;
            sym_count = 0;
            sym_overflow = 1'b0;
            expected_chars.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mtd_pkg::CFG_DOT_MIN:  dot_min = i_cfg_data;
                    mtd_pkg::CFG_DOT_MAX:  dot_max = i_cfg_data;
                    mtd_pkg::CFG_LONG_MIN: long_min = i_cfg_data;
                    mtd_pkg::CFG_LONG_MAX: long_max = i_cfg_data;
                    mtd_pkg::CFG_WORD_MIN: word_min = i_cfg_data;
                    mtd_pkg::CFG_WORD_MAX: word_max = i_cfg_data;
                    default: ;
                endcase
            end
            // A result taken now comes from an earlier request, so compare first.
            if (i_out_valid && !i_out_stall) compare_result(i_out);
            if (i_in_valid && !i_in_stall) predict_key_event(i_in);
        end
        o_pending <= expected_chars.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> sim/morse_edge_timing_decoder_tb.sv
// Testbench top: drives key events and window settings into the decoder and gives the verdict.
module morse_edge_timing_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         KEY_ELEMENTS = 6;
    localparam int         QUIET_LIMIT  = 2000;
    // Indexes past the register list; writes to them must change nothing.
    localparam logic [2:0] CFG_SPARE_A  = 3'd6;
    localparam logic [2:0] CFG_SPARE_B  = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               key_valid = 1'b0;
    logic               key_stall;
    mtd_pkg::t_in_item  key_req = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    mtd_pkg::t_out_item res_item;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = mtd_pkg::CFG_DOT_MIN;
    logic [15:0]        cfg_data = '0;

    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    int          keys_sent = 0;
    bit          calm = 1'b0;
    logic        key_level_now = 1'b0;
    logic [31:0] t_now = '0;
    logic [15:0] win [6];

    morse_edge_timing_decoder #(
        .MAX_ELEMENTS(KEY_ELEMENTS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (key_valid),
        .o_in_stall  (key_stall),
        .i_in        (key_req),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out       (res_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    morse_decode_check #(
        .MAX_ELEMENTS(KEY_ELEMENTS)
    ) u_decode_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (key_valid),
        .i_in_stall   (key_stall),
        .i_in         (key_req),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_out        (res_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5ns clk = ~clk;

    // The character receiver stalls at random except during the calm phase.
    always @(posedge clk) begin
        if (calm) begin
            res_stall <= 1'b0;
        end else begin
            res_stall <= ($urandom_range(99) < 25);
        end
    end

    // Give up when no channel has moved a request for too long.
    always @(posedge clk) begin
        if (!rst_n || (key_valid && !key_stall) || (res_valid && !res_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("morse_edge_timing_decoder test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Send one key event request, elapsed milliseconds after the previous one.
    task automatic send_key(input logic lvl, input logic [31:0] elapsed);
        if (!calm && $urandom_range(99) < 25) begin
            key_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        t_now = t_now + elapsed;
        key_valid <= 1'b1;
        key_req.key_level <= lvl;
        key_req.time_ms <= t_now;
        @(posedge clk);
        while (key_stall) @(posedge clk);
        key_level_now = lvl;
        keys_sent++;
    endtask

    // A duration strictly inside a window, or any 16-bit duration if the window is empty.
    function automatic logic [31:0] pick_inside(input logic [15:0] lo, hi);
        if (hi > lo + 1) return $urandom_range(hi - 1, lo + 1);
        return $urandom_range(65535);
    endfunction

    // Hold the key requests back until every expected character has come out.
    task automatic settle();
        key_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write request; valid stays high for a following write.
    task automatic cfg_write_one(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Load all six windows while the decoder is idle.
    task automatic load_windows(input logic [15:0] dmin, dmax, lmin, lmax, wmin, wmax,
                                input bit spare);
        settle();
        win[mtd_pkg::CFG_DOT_MIN] = dmin;
        win[mtd_pkg::CFG_DOT_MAX] = dmax;
        win[mtd_pkg::CFG_LONG_MIN] = lmin;
        win[mtd_pkg::CFG_LONG_MAX] = lmax;
        win[mtd_pkg::CFG_WORD_MIN] = wmin;
        win[mtd_pkg::CFG_WORD_MAX] = wmax;
        cfg_write_one(mtd_pkg::CFG_DOT_MIN, dmin);
        cfg_write_one(mtd_pkg::CFG_DOT_MAX, dmax);
        cfg_write_one(mtd_pkg::CFG_LONG_MIN, lmin);
        cfg_write_one(mtd_pkg::CFG_LONG_MAX, lmax);
        cfg_write_one(mtd_pkg::CFG_WORD_MIN, wmin);
        cfg_write_one(mtd_pkg::CFG_WORD_MAX, wmax);
        if (spare) begin
            cfg_write_one(CFG_SPARE_A, 16'($urandom_range(65535)));
            cfg_write_one(CFG_SPARE_B, 16'($urandom_range(65535)));
        end
        cfg_valid <= 1'b0;
    endtask

    // A keyed symbol with random content, closed by a letter gap, a word gap or a stray edge.
    task automatic send_symbol();
        int n;
        int k;
        int roll;
        n = ($urandom_range(99) < 85) ? $urandom_range(5, 1) : $urandom_range(7, 6);
        if (!key_level_now)
            send_key(1'b1, pick_inside(win[mtd_pkg::CFG_LONG_MIN], win[mtd_pkg::CFG_LONG_MAX]));
        for (k = 0; k < n; k++) begin
            if ($urandom_range(1))
                send_key(1'b0,
                         pick_inside(win[mtd_pkg::CFG_LONG_MIN], win[mtd_pkg::CFG_LONG_MAX]));
            else
                send_key(1'b0,
                         pick_inside(win[mtd_pkg::CFG_DOT_MIN], win[mtd_pkg::CFG_DOT_MAX]));
            if (k != n - 1)
                send_key(1'b1,
                         pick_inside(win[mtd_pkg::CFG_DOT_MIN], win[mtd_pkg::CFG_DOT_MAX]));
        end
        roll = $urandom_range(99);
        if (roll < 50) begin
            send_key(1'b1, pick_inside(win[mtd_pkg::CFG_LONG_MIN], win[mtd_pkg::CFG_LONG_MAX]));
        end else if (roll < 85) begin
            send_key(1'b1, pick_inside(win[mtd_pkg::CFG_WORD_MIN], win[mtd_pkg::CFG_WORD_MAX]));
        end else if (roll < 93) begin
            // A mark of odd length closes the symbol on the falling edge.
            send_key(1'b1, pick_inside(win[mtd_pkg::CFG_DOT_MIN], win[mtd_pkg::CFG_DOT_MAX]));
            send_key(1'b0, {16'd0, win[3'($urandom_range(5))]});
        end else begin
            send_key(1'b1, $urandom());
        end
    endtask

    // A lone edge of either level, often right on a window bound.
    task automatic send_noise();
        logic [15:0] bound;
        logic [31:0] elapsed;
        bound = win[3'($urandom_range(5))];
        case ($urandom_range(5))
            0:       elapsed = {16'd0, bound};
            1:       elapsed = {16'd0, bound} + 32'd1;
            2:       elapsed = {16'd0, bound} - 32'd1;
            3:       elapsed = $urandom();
            4:       elapsed = '0;
            default: elapsed = $urandom_range(65535);
        endcase
        send_key(1'($urandom_range(1)), elapsed);
    endtask

    // Mostly well-formed symbols, the rest stray edges.
    task automatic run_keys(input int count);
        int stop;
        stop = keys_sent + count;
        while (keys_sent < stop) begin
            if ($urandom_range(99) < 75) send_symbol();
            else send_noise();
        end
    endtask

    initial begin
        logic [15:0] r_dot, r_long, r_word;
        int k;
        win[mtd_pkg::CFG_DOT_MIN] = mtd_pkg::RST_DOT_MIN;
        win[mtd_pkg::CFG_DOT_MAX] = mtd_pkg::RST_DOT_MAX;
        win[mtd_pkg::CFG_LONG_MIN] = mtd_pkg::RST_LONG_MIN;
        win[mtd_pkg::CFG_LONG_MAX] = mtd_pkg::RST_LONG_MAX;
        win[mtd_pkg::CFG_WORD_MIN] = mtd_pkg::RST_WORD_MIN;
        win[mtd_pkg::CFG_WORD_MAX] = mtd_pkg::RST_WORD_MAX;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed events on the reset windows; the stamps wrap right at the start.
        send_key(1'b1, 32'hFFFF_FFFF);   // huge gap, nothing
        send_key(1'b0, 32'd1);           // stamp zero, short mark on an empty buffer
        send_key(1'b1, 32'd250);         // gap outside both windows
        send_key(1'b0, 32'd250);         // dot
        send_key(1'b1, 32'd750);         // letter gap gives E
        send_key(1'b0, 32'd750);         // dash
        send_key(1'b1, 32'd1000);        // word gap gives T and a space
        send_key(1'b1, 32'd300);         // same level twice
        for (k = 0; k < 4; k++) begin
            send_key(1'b0, 32'd250);
            send_key(1'b1, 32'd250);
        end
        send_key(1'b0, 32'd750);
        send_key(1'b1, 32'd750);         // four dots and a dash give the digit four
        send_key(1'b0, 32'd255);         // mark on the dot bound, empty buffer decoded
        send_key(1'b1, 32'd1000);        // word gap alone gives a space
        send_key(1'b0, 32'd746);
        send_key(1'b1, 32'd754);         // just inside the dash and letter windows
        send_key(1'b0, 32'd254);
        send_key(1'b1, 32'd1004);        // just inside the dot and word windows

        // Random symbols on the reset windows, then a stretch with no idling.
        run_keys(130);
        calm = 1'b1;
        run_keys(100);
        calm = 1'b0;

        // Short windows, overlapping windows, and the extremes.
        load_windows(16'd10, 16'd30, 16'd40, 16'd80, 16'd90, 16'd200, 1'b0);
        run_keys(120);
        load_windows(16'd100, 16'd400, 16'd200, 16'd500, 16'd300, 16'd600, 1'b1);
        run_keys(120);
        load_windows(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        run_keys(40);
        load_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        run_keys(40);
        load_windows(16'd0, 16'd2, 16'd60000, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
        run_keys(80);

        // Random windows of moderate width.
        r_dot = 16'($urandom_range(2000));
        r_long = 16'($urandom_range(4000));
        r_word = 16'($urandom_range(6000));
        load_windows(r_dot, r_dot + 16'($urandom_range(300, 2)),
                     r_long, r_long + 16'($urandom_range(300, 2)),
                     r_word, r_word + 16'($urandom_range(300, 2)), 1'b1);
        run_keys(100);

        // Back to the reset windows.
        load_windows(mtd_pkg::RST_DOT_MIN, mtd_pkg::RST_DOT_MAX,
                     mtd_pkg::RST_LONG_MIN, mtd_pkg::RST_LONG_MAX,
                     mtd_pkg::RST_WORD_MIN, mtd_pkg::RST_WORD_MAX, 1'b1);
        run_keys(100);

        settle();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("morse_edge_timing_decoder test passed");
        end else begin
            $display("morse_edge_timing_decoder test failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/mtd_pkg.sv
rtl/morse_edge_timing_decoder.sv
rtl/mtd_checker.sv
sim/morse_decode_check.sv
sim/morse_edge_timing_decoder_tb.sv
